// ===== hw/rtl/gqtn_pkg.sv =====
package gqtn_pkg;

   localparam int GRID_VERTICES = 257;

   localparam int COORD_W = 8;
   localparam int H_W     = 24;
   localparam int SPC_W   = 23;
   localparam int IDX_W   = 17;
   localparam int NRM_W   = 16;

   localparam int V_W     = H_W + 1;
   localparam int L1_W    = V_W + 1;
   localparam int R_W     = L1_W + 1;
   localparam int Q_W     = 15;
   localparam int DIV_STAGES = Q_W;
   localparam int NCOMP   = 3;

   localparam int REQ_DATA_W = 112;
   localparam int RSP_DATA_W = 104;

   localparam logic [SPC_W-1:0] SPACING_RESET = SPC_W'(3200);

   typedef struct packed {
      logic [IDX_W-1:0] vertex_a;
      logic [IDX_W-1:0] vertex_b;
      logic [IDX_W-1:0] vertex_c;
      logic             degenerate;
      logic             last;
   } tri_meta_type;

endpackage

// ===== hw/rtl/grid_quad_triangulate_normals.sv =====
// Heightfield quad triangulator with L1-normalised face normals.
//
// The req_ channel takes one quad per transaction: column, row and the four
// corner heights. The rsp_ channel returns two triangle transactions for it,
// the second one marked by rsp_tlast. Each carries three vertex indices and
// a Q1.14 normal; rsp_tuser flags a degenerate triangle (zero spacing).
// The csr_ channel writes the cell spacing; it is always ready and must only
// be used while the block is idle.
//
// A new quad is taken only while the input register is empty or is issuing
// the second triangle of the quad it holds; one triangle leaves per cycle
// while the receiver is ready. From acceptance to rsp_, a quad sits in the
// input register, then passes an edge vector stage, an L1 norm stage, fifteen
// restoring divider stages with one quotient bit each, and the output register.
//
// Reset is synchronous and empties the pipeline; the spacing returns to
// 3200. When the receiver stalls, the whole pipeline holds and nothing is
// lost or repeated; req_tready drops until the output moves again.
module grid_quad_triangulate_normals (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // col, row, height_here, height_next_col, height_next_row, height_diagonal
   input  logic [gqtn_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // vertex_a, vertex_b, vertex_c, normal_x, normal_y, normal_z, zero padding
   output logic [gqtn_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // degenerate
   output logic         rsp_tuser,
   output logic         rsp_tlast,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [gqtn_pkg::SPC_W-1:0] csr_data
);

   localparam int R = gqtn_pkg::R_W;
   localparam int V = gqtn_pkg::V_W;
   localparam int L = gqtn_pkg::L1_W;
   localparam int Q = gqtn_pkg::Q_W;
   localparam int D = gqtn_pkg::DIV_STAGES;
   localparam int C = gqtn_pkg::NCOMP;
   localparam int I = gqtn_pkg::IDX_W;

   logic adv;

   logic [gqtn_pkg::SPC_W-1:0] spacing_ff, spacing_in;

   logic        quad_valid_ff, quad_valid_in;
   logic        quad_phase_ff, quad_phase_in;
   logic [gqtn_pkg::COORD_W-1:0] col_ff, col_in, row_ff, row_in;
   logic signed [gqtn_pkg::H_W-1:0] h0_ff, h0_in, hc_ff, hc_in, hr_ff, hr_in, hd_ff, hd_in;

   logic        vec_valid_ff, vec_valid_in;
   logic signed [V-1:0] vec_x_ff, vec_x_in, vec_z_ff, vec_z_in;
   logic [gqtn_pkg::SPC_W-1:0] vec_y_ff, vec_y_in;
   gqtn_pkg::tri_meta_type vec_meta_ff, vec_meta_in;

   logic        nrm_valid_ff, nrm_valid_in;
   logic [R-1:0] nrm_num_ff [C], nrm_num_in [C];
   logic [C-1:0] nrm_neg_ff, nrm_neg_in;
   logic [L-1:0] nrm_den_ff, nrm_den_in;
   gqtn_pkg::tri_meta_type nrm_meta_ff, nrm_meta_in;

   logic [D-1:0] div_valid_ff, div_valid_in;
   logic [R-1:0] div_rem_ff [D][C], div_rem_in [D][C];
   logic [Q-1:0] div_quo_ff [D][C], div_quo_in [D][C];
   logic [C-1:0] div_neg_ff [D], div_neg_in [D];
   logic [L-1:0] div_den_ff [D], div_den_in [D];
   gqtn_pkg::tri_meta_type div_meta_ff [D], div_meta_in [D];

   logic        out_valid_ff, out_valid_in;
   logic [gqtn_pkg::NRM_W-1:0] out_nrm_ff [C], out_nrm_in [C];
   gqtn_pkg::tri_meta_type out_meta_ff, out_meta_in;

   logic req_accept;
   logic [I-1:0] idx_here, idx_next_row;

   assign adv        = !out_valid_ff || rsp_tready;
   assign req_tready = adv && (!quad_valid_ff || quad_phase_ff);
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   always_comb begin
      spacing_in = spacing_ff;
      if (csr_valid) begin
         spacing_in = csr_data;
      end
   end

   always_comb begin
      quad_valid_in = quad_valid_ff;
      quad_phase_in = quad_phase_ff;
      col_in = col_ff;
      row_in = row_ff;
      h0_in  = h0_ff;
      hc_in  = hc_ff;
      hr_in  = hr_ff;
      hd_in  = hd_ff;
      if (adv) begin
         if (quad_valid_ff && !quad_phase_ff) begin
            quad_phase_in = 1'b1;
         end else begin
            quad_valid_in = req_accept;
            quad_phase_in = 1'b0;
         end
      end
      if (req_accept) begin
         col_in = req_tdata[7:0];
         row_in = req_tdata[15:8];
         h0_in  = req_tdata[39:16];
         hc_in  = req_tdata[63:40];
         hr_in  = req_tdata[87:64];
         hd_in  = req_tdata[111:88];
      end
   end

   assign idx_here     = I'(row_ff) * I'(gqtn_pkg::GRID_VERTICES) + I'(col_ff);
   assign idx_next_row = idx_here + I'(gqtn_pkg::GRID_VERTICES);

   always_comb begin
      vec_valid_in = vec_valid_ff;
      vec_x_in     = vec_x_ff;
      vec_y_in     = vec_y_ff;
      vec_z_in     = vec_z_ff;
      vec_meta_in  = vec_meta_ff;
      if (adv) begin
         vec_valid_in = quad_valid_ff;
         vec_y_in     = spacing_ff;
         vec_meta_in.degenerate = (spacing_ff == '0);
         vec_meta_in.last       = quad_phase_ff;
         if (!quad_phase_ff) begin
            vec_x_in = V'(hr_ff) - V'(hd_ff);
            vec_z_in = V'(h0_ff) - V'(hr_ff);
            vec_meta_in.vertex_a = idx_here;
            vec_meta_in.vertex_b = idx_next_row;
            vec_meta_in.vertex_c = idx_next_row + I'(1);
         end else begin
            vec_x_in = V'(h0_ff) - V'(hc_ff);
            vec_z_in = V'(hc_ff) - V'(hd_ff);
            vec_meta_in.vertex_a = idx_next_row + I'(1);
            vec_meta_in.vertex_b = idx_here;
            vec_meta_in.vertex_c = idx_here + I'(1);
         end
      end
   end

   always_comb begin
      logic [V-1:0] ax;
      logic [V-1:0] az;
      nrm_valid_in = nrm_valid_ff;
      nrm_num_in   = nrm_num_ff;
      nrm_neg_in   = nrm_neg_ff;
      nrm_den_in   = nrm_den_ff;
      nrm_meta_in  = nrm_meta_ff;
      ax = vec_x_ff[V-1] ? V'(-vec_x_ff) : V'(vec_x_ff);
      az = vec_z_ff[V-1] ? V'(-vec_z_ff) : V'(vec_z_ff);
      if (adv) begin
         nrm_valid_in = vec_valid_ff;
         nrm_meta_in  = vec_meta_ff;
         if (vec_meta_ff.degenerate) begin
            nrm_num_in[0] = '0;
            nrm_num_in[1] = '0;
            nrm_num_in[2] = '0;
            nrm_neg_in    = '0;
            nrm_den_in    = L'(1);
         end else begin
            nrm_num_in[0] = R'(ax);
            nrm_num_in[1] = R'(vec_y_ff);
            nrm_num_in[2] = R'(az);
            nrm_neg_in    = {vec_z_ff[V-1], 1'b0, vec_x_ff[V-1]};
            nrm_den_in    = L'(ax) + L'(az) + L'(vec_y_ff);
         end
      end
   end

   always_comb begin
      logic [R-1:0] part;
      logic [R-1:0] den;
      logic         hit;
      div_valid_in = div_valid_ff;
      div_rem_in   = div_rem_ff;
      div_quo_in   = div_quo_ff;
      div_neg_in   = div_neg_ff;
      div_den_in   = div_den_ff;
      div_meta_in  = div_meta_ff;
      part = '0;
      den  = '0;
      hit  = 1'b0;
      if (adv) begin
         for (int k = 0; k < D; k++) begin
            if (k == 0) begin
               div_valid_in[k] = nrm_valid_ff;
               div_neg_in[k]   = nrm_neg_ff;
               div_den_in[k]   = nrm_den_ff;
               div_meta_in[k]  = nrm_meta_ff;
               den = R'(nrm_den_ff);
            end else begin
               div_valid_in[k] = div_valid_ff[k-1];
               div_neg_in[k]   = div_neg_ff[k-1];
               div_den_in[k]   = div_den_ff[k-1];
               div_meta_in[k]  = div_meta_ff[k-1];
               den = R'(div_den_ff[k-1]);
            end
            for (int c = 0; c < C; c++) begin
               if (k == 0) begin
                  part = nrm_num_ff[c];
               end else begin
                  part = {div_rem_ff[k-1][c][R-2:0], 1'b0};
               end
               hit = (part >= den);
               div_rem_in[k][c] = hit ? part - den : part;
               if (k == 0) begin
                  div_quo_in[k][c] = Q'(hit);
               end else begin
                  div_quo_in[k][c] = {div_quo_ff[k-1][c][Q-2:0], hit};
               end
            end
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_nrm_in   = out_nrm_ff;
      out_meta_in  = out_meta_ff;
      if (adv) begin
         out_valid_in = div_valid_ff[D-1];
         out_meta_in  = div_meta_ff[D-1];
         for (int c = 0; c < C; c++) begin
            if (div_neg_ff[D-1][c]) begin
               out_nrm_in[c] = -gqtn_pkg::NRM_W'(div_quo_ff[D-1][c]);
            end else begin
               out_nrm_in[c] = gqtn_pkg::NRM_W'(div_quo_ff[D-1][c]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spacing_ff    <= gqtn_pkg::SPACING_RESET;
         quad_valid_ff <= 1'b0;
         quad_phase_ff <= 1'b0;
         vec_valid_ff  <= 1'b0;
         nrm_valid_ff  <= 1'b0;
         div_valid_ff  <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         spacing_ff    <= spacing_in;
         quad_valid_ff <= quad_valid_in;
         quad_phase_ff <= quad_phase_in;
         vec_valid_ff  <= vec_valid_in;
         nrm_valid_ff  <= nrm_valid_in;
         div_valid_ff  <= div_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      col_ff      <= col_in;
      row_ff      <= row_in;
      h0_ff       <= h0_in;
      hc_ff       <= hc_in;
      hr_ff       <= hr_in;
      hd_ff       <= hd_in;
      vec_x_ff    <= vec_x_in;
      vec_y_ff    <= vec_y_in;
      vec_z_ff    <= vec_z_in;
      vec_meta_ff <= vec_meta_in;
      nrm_num_ff  <= nrm_num_in;
      nrm_neg_ff  <= nrm_neg_in;
      nrm_den_ff  <= nrm_den_in;
      nrm_meta_ff <= nrm_meta_in;
      div_rem_ff  <= div_rem_in;
      div_quo_ff  <= div_quo_in;
      div_neg_ff  <= div_neg_in;
      div_den_ff  <= div_den_in;
      div_meta_ff <= div_meta_in;
      out_nrm_ff  <= out_nrm_in;
      out_meta_ff <= out_meta_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_meta_ff.degenerate;
   assign rsp_tlast  = out_meta_ff.last;
   assign rsp_tdata  = {5'd0, out_nrm_ff[2], out_nrm_ff[1], out_nrm_ff[0],
                        out_meta_ff.vertex_c, out_meta_ff.vertex_b,
                        out_meta_ff.vertex_a};

`ifndef SYNTH
   // A degenerate triangle carries a zero normal.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[98:51] == '0)
      else $error("degenerate triangle with a non-zero normal");

   // The first triangle of a quad is always followed by its second one.
   assert property (@(posedge clock) disable iff (reset)
      quad_valid_ff && !quad_phase_ff && adv |=> quad_valid_ff && quad_phase_ff)
      else $error("second triangle of a quad was not issued");

   // After the first divider step every remainder lies below the divisor.
   assert property (@(posedge clock) disable iff (reset)
      div_valid_ff[0] |-> div_rem_ff[0][0] < R'(div_den_ff[0])
                       && div_rem_ff[0][1] < R'(div_den_ff[0])
                       && div_rem_ff[0][2] < R'(div_den_ff[0]))
      else $error("divider remainder out of range");
`endif

endmodule

// ===== tb/grid_quad_triangulate_normals_tb.sv =====
module grid_quad_triangulate_normals_tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [gqtn_pkg::IDX_W-1:0] vertex_a;
      logic [gqtn_pkg::IDX_W-1:0] vertex_b;
      logic [gqtn_pkg::IDX_W-1:0] vertex_c;
      logic [gqtn_pkg::NRM_W-1:0] normal_x;
      logic [gqtn_pkg::NRM_W-1:0] normal_y;
      logic [gqtn_pkg::NRM_W-1:0] normal_z;
      logic             degenerate;
      logic             last;
   } triangle_type;

   localparam int LIMIT_CYCLES = 100000;
   localparam int HOLD_CYCLES  = 300;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [111:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [103:0] rsp_tdata;
   logic         rsp_tuser;
   logic         rsp_tlast;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [22:0]  csr_data = '0;

   triangle_type expected_triangles[$];
   logic [22:0]  spacing_model = gqtn_pkg::SPACING_RESET;
   int           error_count = 0;
   int           quads_sent = 0;
   int           triangles_seen = 0;
   int           cycle_count = 0;
   int           degenerate_seen = 0;
   int           hold_count = 0;
   bit           hold_request = 1'b0;
   bit           stall_pattern = 1'b1;

   grid_quad_triangulate_normals dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic triangle_type face_normal(longint a, longint b, longint c,
                                                longint x, longint y, longint z,
                                                bit is_last);
      triangle_type t;
      longint l1;
      l1 = (x < 0 ? -x : x) + (y < 0 ? -y : y) + (z < 0 ? -z : z);
      t.vertex_a = a[gqtn_pkg::IDX_W-1:0];
      t.vertex_b = b[gqtn_pkg::IDX_W-1:0];
      t.vertex_c = c[gqtn_pkg::IDX_W-1:0];
      t.last = is_last;
      if (spacing_model == 0 || l1 == 0) begin
         t.normal_x = '0;
         t.normal_y = '0;
         t.normal_z = '0;
         t.degenerate = 1'b1;
      end else begin
         t.normal_x = gqtn_pkg::NRM_W'((x * 16384) / l1);
         t.normal_y = gqtn_pkg::NRM_W'((y * 16384) / l1);
         t.normal_z = gqtn_pkg::NRM_W'((z * 16384) / l1);
         t.degenerate = 1'b0;
      end
      return t;
   endfunction

   task automatic predict_quad(logic [7:0] col, logic [7:0] row,
                               logic signed [23:0] h0, logic signed [23:0] hc,
                               logic signed [23:0] hr, logic signed [23:0] hd);
      longint here, nextrow, s;
      here = longint'(row) * gqtn_pkg::GRID_VERTICES + longint'(col);
      nextrow = (longint'(row) + 1) * gqtn_pkg::GRID_VERTICES + longint'(col);
      s = longint'(spacing_model);
      expected_triangles.push_back(face_normal(here, nextrow, nextrow + 1,
         longint'(hr) - longint'(hd), s, longint'(h0) - longint'(hr), 1'b0));
      expected_triangles.push_back(face_normal(nextrow + 1, here, here + 1,
         longint'(h0) - longint'(hc), s, longint'(hc) - longint'(hd), 1'b1));
   endtask

   task automatic send_quad(logic [7:0] col, logic [7:0] row,
                            logic signed [23:0] h0, logic signed [23:0] hc,
                            logic signed [23:0] hr, logic signed [23:0] hd);
      req_tdata <= {hd, hr, hc, h0, row, col};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_quad(col, row, h0, hc, hr, hd);
      quads_sent++;
   endtask

   task automatic idle_sender(int cycles);
      req_tvalid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic drain();
      idle_sender(1);
      while (expected_triangles.size() != 0) @(posedge clock);
      repeat (25) @(posedge clock);
   endtask

   task automatic write_spacing(logic [22:0] value);
      drain();
      csr_data <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      spacing_model = value;
   endtask

   function automatic logic signed [23:0] random_height(int mode);
      case (mode)
         0: return 24'sh800000;
         1: return 24'sh7FFFFF;
         2: return 24'(($urandom_range(0, 512)) - 256);
         default: return 24'($urandom);
      endcase
   endfunction

   task automatic send_random_quads(int count, bit bursty);
      int burst;
      int sent;
      sent = 0;
      burst = $urandom_range(1, 20);
      while (sent < count) begin
         send_quad(8'($urandom), 8'($urandom),
                   random_height($urandom_range(0, 7)),
                   random_height($urandom_range(0, 7)),
                   random_height($urandom_range(0, 7)),
                   random_height($urandom_range(0, 7)));
         sent++;
         burst--;
         if (bursty && burst == 0) begin
            idle_sender($urandom_range(1, 6));
            burst = $urandom_range(1, 20);
         end
      end
   endtask

   task automatic test_directed_extremes();
      send_quad(8'd0, 8'd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0);
      send_quad(8'd255, 8'd255, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 24'sh800000);
      send_quad(8'd255, 8'd0, 24'sh800000, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF);
      send_quad(8'd0, 8'd255, 24'sh800000, 24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF);
      send_quad(8'hAA, 8'h55, 24'sh555555, 24'shAAAAAA, 24'sd1, -24'sd1);
      send_quad(8'h55, 8'hAA, 24'shAAAAAA, 24'sh555555, -24'sd1, 24'sd1);
      send_quad(8'd17, 8'd3, 24'sd256, 24'sd512, 24'sd768, 24'sd1024);
      drain();
   endtask

   task automatic test_spacing_extremes();
      write_spacing(23'd0);
      send_quad(8'd4, 8'd9, 24'sd100, -24'sd100, 24'sd7, 24'sh7FFFFF);
      send_random_quads(6, 1'b0);
      write_spacing(23'd1);
      send_quad(8'd1, 8'd2, 24'sd0, 24'sd0, 24'sd0, 24'sd0);
      send_quad(8'd1, 8'd2, 24'sh7FFFFF, 24'sh800000, 24'sh800000, 24'sh7FFFFF);
      send_random_quads(5, 1'b0);
      write_spacing(23'h7FFFFF);
      send_quad(8'd8, 8'd8, 24'sd0, 24'sd0, 24'sd0, 24'sd0);
      send_quad(8'd8, 8'd8, 24'sh7FFFFF, 24'sh800000, 24'sh800000, 24'sh7FFFFF);
      send_random_quads(5, 1'b0);
   endtask

   task automatic test_random_spacings();
      for (int phase = 0; phase < 6; phase++) begin
         case (phase % 3)
            0: write_spacing(23'($urandom_range(1, 4096)));
            1: write_spacing(23'($urandom));
            default: write_spacing(23'($urandom_range(0, 3)));
         endcase
         send_random_quads(240, 1'b1);
      end
      write_spacing(gqtn_pkg::SPACING_RESET);
      send_random_quads(200, 1'b1);
   endtask

   task automatic test_back_pressure();
      drain();
      hold_request = 1'b1;
      send_random_quads(40, 1'b0);
      hold_request = 1'b0;
      drain();
      send_random_quads(40, 1'b0);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_count <= 0;
      end else if (hold_request && hold_count < HOLD_CYCLES) begin
         rsp_tready <= 1'b0;
         hold_count <= hold_count + 1;
      end else begin
         if (!hold_request) hold_count <= 0;
         if ($urandom_range(0, 63) == 0) stall_pattern <= ~stall_pattern;
         rsp_tready <= stall_pattern ? 1'b1 : ($urandom_range(0, 2) != 0);
      end
   end

   always @(posedge clock) begin
      triangle_type got;
      triangle_type want;
      cycle_count++;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.vertex_a   = rsp_tdata[16:0];
         got.vertex_b   = rsp_tdata[33:17];
         got.vertex_c   = rsp_tdata[50:34];
         got.normal_x   = rsp_tdata[66:51];
         got.normal_y   = rsp_tdata[82:67];
         got.normal_z   = rsp_tdata[98:83];
         got.degenerate = rsp_tuser;
         got.last       = rsp_tlast;
         triangles_seen++;
         if (got.degenerate) degenerate_seen++;
         if (expected_triangles.size() == 0) begin
            $error("Unexpected triangle transaction %h", got);
            error_count++;
         end else begin
            want = expected_triangles.pop_front();
            if (got.vertex_a !== want.vertex_a) begin
               $error("vertex_a: expected %0d, got %0d", want.vertex_a, got.vertex_a);
               error_count++;
            end
            if (got.vertex_b !== want.vertex_b) begin
               $error("vertex_b: expected %0d, got %0d", want.vertex_b, got.vertex_b);
               error_count++;
            end
            if (got.vertex_c !== want.vertex_c) begin
               $error("vertex_c: expected %0d, got %0d", want.vertex_c, got.vertex_c);
               error_count++;
            end
            if (got.normal_x !== want.normal_x) begin
               $error("normal_x: expected %h, got %h", want.normal_x, got.normal_x);
               error_count++;
            end
            if (got.normal_y !== want.normal_y) begin
               $error("normal_y: expected %h, got %h", want.normal_y, got.normal_y);
               error_count++;
            end
            if (got.normal_z !== want.normal_z) begin
               $error("normal_z: expected %h, got %h", want.normal_z, got.normal_z);
               error_count++;
            end
            if (got.degenerate !== want.degenerate) begin
               $error("degenerate: expected %b, got %b", want.degenerate, got.degenerate);
               error_count++;
            end
            if (got.last !== want.last) begin
               $error("last: expected %b, got %b", want.last, got.last);
               error_count++;
            end
         end
      end
      if (cycle_count > LIMIT_CYCLES) begin
         $display("Timed out with %0d transactions outstanding.",
                  expected_triangles.size());
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_extremes();
      test_spacing_extremes();
      test_back_pressure();
      test_random_spacings();
      drain();
      $display("Sent %0d quads and checked %0d triangle transactions, %0d degenerate.",
               quads_sent, triangles_seen, degenerate_seen);
      $display("Spacing covered zero, one, full scale and random values.");
      if (error_count == 0 && expected_triangles.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule

// ===== filelist.f =====
hw/rtl/gqtn_pkg.sv
hw/rtl/grid_quad_triangulate_normals.sv
tb/grid_quad_triangulate_normals_tb.sv
